// ----- rtl/bcd_pkg.sv -----
package bcd_pkg;

  // digest trailer length in bytes
  localparam int unsigned TRAILER_BYTES = 32;

  // byte counter also walks the four magic bytes, so it never drops below 3 bits
  localparam int unsigned CNT_W =
    ($clog2(TRAILER_BYTES + 1) > 3) ? $clog2(TRAILER_BYTES + 1) : 3;

  // varint shift holds 0..63 plus one step of 7
  localparam int unsigned SHIFT_W = 7;

  localparam int unsigned LEN_W = 64;

  // reset value of the original length cap
  localparam logic [LEN_W-1:0] MAX_OLEN_RST = 64'd1 << 34;

  // result queue depth and pointer width
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_TAG     = 3'd1,
    PH_FLAGS   = 3'd2,
    PH_ORIG    = 3'd3,
    PH_COMP    = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_TRAILER = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    K_DATA   = 3'd0,
    K_HEADER = 3'd1,
    K_DIGEST = 3'd2,
    K_OK     = 3'd3,
    K_ERROR  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE    = 3'd0,
    E_MAGIC   = 3'd1,
    E_TAG     = 3'd2,
    E_VARINT  = 3'd3,
    E_TRUNC   = 3'd4,
    E_CAP     = 3'd5,
    E_TRAILER = 3'd6
  } err_t;

  // block tags
  localparam logic [7:0] TAG_END   = 8'h00;
  localparam logic [7:0] TAG_BLOCK = 8'h01;

  typedef struct packed {
    kind_t            kind;
    logic [7:0]       value;
    logic [7:0]       flags;
    logic [LEN_W-1:0] olen;
    logic [LEN_W-1:0] plen;
    err_t             err;
    logic             last;
  } result_t;

  // up to two results written into the queue per transaction
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t r0;
    result_t r1;
  } push_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = 8'h50;
      2'd1:    b = 8'h41;
      2'd2:    b = 8'h53;
      default: b = 8'h31;
    endcase
    return b;
  endfunction

endpackage

// ----- rtl/bcd_parse.sv -----
module bcd_parse (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [7:0]               in_byte,
  input  logic                     in_last,
  input  logic                     cfg_wr_en,
  input  logic [bcd_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                     room,
  output bcd_pkg::push_t           push
);

  // input register
  logic       s_valid_r;
  logic [7:0] s_byte_r;
  logic       s_last_r;
  logic       fire;

  // parser state
  bcd_pkg::phase_t              phase_r, phase_nxt;
  logic [bcd_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [bcd_pkg::LEN_W-1:0]    acc_r, acc_nxt;
  logic [bcd_pkg::SHIFT_W-1:0]  shift_r, shift_nxt;
  logic [7:0]                   flags_r, flags_nxt;
  logic [bcd_pkg::LEN_W-1:0]    olen_r, olen_nxt;
  logic [bcd_pkg::LEN_W-1:0]    rem_r, rem_nxt;
  logic                         err_r, err_nxt;
  logic [bcd_pkg::LEN_W-1:0]    max_olen_r;

  // decode helpers
  logic                         m_v;
  logic                         t_v;
  bcd_pkg::result_t             m_res;
  bcd_pkg::result_t             t_res;
  logic                         do_clear;
  logic                         do_latch;
  logic [bcd_pkg::LEN_W-1:0]    acc_or;
  logic [bcd_pkg::SHIFT_W-1:0]  shift_sum;
  logic [bcd_pkg::LEN_W-1:0]    rem_dec;
  logic [bcd_pkg::CNT_W-1:0]    cnt_inc;

  assign fire     = s_valid_r & room;
  assign in_ready = ~s_valid_r | room;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ready) begin
      s_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s_byte_r <= in_byte;
      s_last_r <= in_last;
    end
  end

  // length cap register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_olen_r <= bcd_pkg::MAX_OLEN_RST;
    end else if (cfg_wr_en) begin
      max_olen_r <= cfg_wr_data;
    end
  end

  assign acc_or    = acc_r | ({{(bcd_pkg::LEN_W-7){1'b0}}, s_byte_r[6:0]} << shift_r[5:0]);
  assign shift_sum = shift_r + bcd_pkg::SHIFT_W'(7);
  assign rem_dec   = (rem_r != '0) ? (rem_r - bcd_pkg::LEN_W'(1)) : rem_r;
  assign cnt_inc   = cnt_r + bcd_pkg::CNT_W'(1);

  // next state and results for the registered byte
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    shift_nxt = shift_r;
    flags_nxt = flags_r;
    olen_nxt  = olen_r;
    rem_nxt   = rem_r;
    err_nxt   = err_r;
    m_v       = 1'b0;
    t_v       = 1'b0;
    m_res     = '0;
    t_res     = '0;
    do_clear  = 1'b0;
    do_latch  = 1'b0;

    if (err_r) begin
      // sticky error: swallow bytes until the final one
      do_clear = s_last_r;
    end else begin
      unique case (phase_r)
        bcd_pkg::PH_MAGIC: begin
          if (s_byte_r != bcd_pkg::magic_byte(cnt_r[1:0]) || s_last_r) begin
            t_v       = 1'b1;
            t_res.err = bcd_pkg::E_MAGIC;
          end else if (cnt_r[1:0] == 2'd3) begin
            cnt_nxt   = '0;
            phase_nxt = bcd_pkg::PH_TAG;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        bcd_pkg::PH_TAG: begin
          if (s_byte_r == bcd_pkg::TAG_END) begin
            if (s_last_r) begin
              t_v       = 1'b1;
              t_res.err = bcd_pkg::E_TRAILER;
            end else begin
              cnt_nxt   = '0;
              phase_nxt = bcd_pkg::PH_TRAILER;
            end
          end else if (s_byte_r == bcd_pkg::TAG_BLOCK) begin
            if (s_last_r) begin
              t_v       = 1'b1;
              t_res.err = bcd_pkg::E_TRUNC;
            end else begin
              phase_nxt = bcd_pkg::PH_FLAGS;
            end
          end else begin
            t_v       = 1'b1;
            t_res.err = bcd_pkg::E_TAG;
          end
        end
        bcd_pkg::PH_FLAGS: begin
          if (s_last_r) begin
            t_v       = 1'b1;
            t_res.err = bcd_pkg::E_TRUNC;
          end else begin
            flags_nxt = s_byte_r;
            acc_nxt   = '0;
            shift_nxt = '0;
            phase_nxt = bcd_pkg::PH_ORIG;
          end
        end
        bcd_pkg::PH_ORIG, bcd_pkg::PH_COMP: begin
          acc_nxt = acc_or;
          if (s_byte_r[7]) begin
            // continuation byte
            shift_nxt = shift_sum;
            if (shift_sum >= bcd_pkg::SHIFT_W'(64)) begin
              t_v       = 1'b1;
              t_res.err = bcd_pkg::E_VARINT;
            end else if (s_last_r) begin
              t_v       = 1'b1;
              t_res.err = bcd_pkg::E_TRUNC;
            end
          end else if (phase_r == bcd_pkg::PH_ORIG) begin
            olen_nxt  = acc_or;
            acc_nxt   = '0;
            shift_nxt = '0;
            if (s_last_r) begin
              t_v       = 1'b1;
              t_res.err = bcd_pkg::E_TRUNC;
            end else begin
              phase_nxt = bcd_pkg::PH_COMP;
            end
          end else begin
            // payload length complete
            acc_nxt   = '0;
            shift_nxt = '0;
            if (s_last_r && acc_or != '0) begin
              t_v       = 1'b1;
              t_res.err = bcd_pkg::E_TRUNC;
            end else if (olen_r > max_olen_r) begin
              t_v       = 1'b1;
              t_res.err = bcd_pkg::E_CAP;
            end else begin
              m_v         = 1'b1;
              m_res.kind  = bcd_pkg::K_HEADER;
              m_res.flags = flags_r;
              m_res.olen  = olen_r;
              m_res.plen  = acc_or;
              rem_nxt     = acc_or;
              phase_nxt   = (acc_or != '0) ? bcd_pkg::PH_PAYLOAD : bcd_pkg::PH_TAG;
              if (s_last_r) begin
                t_v       = 1'b1;
                t_res.err = bcd_pkg::E_TRUNC;
              end
            end
          end
        end
        bcd_pkg::PH_PAYLOAD: begin
          m_v         = 1'b1;
          m_res.kind  = bcd_pkg::K_DATA;
          m_res.value = s_byte_r;
          rem_nxt     = rem_dec;
          if (rem_dec == '0) begin
            phase_nxt = bcd_pkg::PH_TAG;
          end
          if (s_last_r) begin
            t_v       = 1'b1;
            t_res.err = bcd_pkg::E_TRUNC;
          end
        end
        bcd_pkg::PH_TRAILER: begin
          if (cnt_r >= bcd_pkg::CNT_W'(bcd_pkg::TRAILER_BYTES)) begin
            t_v       = 1'b1;
            t_res.err = bcd_pkg::E_TRAILER;
          end else begin
            m_v         = 1'b1;
            m_res.kind  = bcd_pkg::K_DIGEST;
            m_res.value = s_byte_r;
            cnt_nxt     = cnt_inc;
            if (s_last_r) begin
              t_v = 1'b1;
              if (cnt_inc == bcd_pkg::CNT_W'(bcd_pkg::TRAILER_BYTES)) begin
                t_res.kind = bcd_pkg::K_OK;
                do_clear   = 1'b1;
              end else begin
                t_res.err = bcd_pkg::E_TRAILER;
              end
            end
          end
        end
        default: begin
          phase_nxt = bcd_pkg::PH_MAGIC;
        end
      endcase

      // an error result restarts on the final byte, otherwise it sticks
      if (t_v && t_res.kind != bcd_pkg::K_OK) begin
        t_res.kind = bcd_pkg::K_ERROR;
        do_clear   = s_last_r;
        do_latch   = ~s_last_r;
      end
    end

    if (do_latch) begin
      err_nxt = 1'b1;
    end
    if (do_clear) begin
      phase_nxt = bcd_pkg::PH_MAGIC;
      cnt_nxt   = '0;
      acc_nxt   = '0;
      shift_nxt = '0;
      flags_nxt = '0;
      olen_nxt  = '0;
      rem_nxt   = '0;
      err_nxt   = 1'b0;
    end
  end

  // pack results for the queue
  always_comb begin
    push         = '0;
    push.v0      = fire & (m_v | t_v);
    push.v1      = fire & m_v & t_v;
    push.r0      = m_v ? m_res : t_res;
    push.r0.last = ~(m_v & t_v);
    push.r1      = t_res;
    push.r1.last = 1'b1;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= bcd_pkg::PH_MAGIC;
      cnt_r   <= '0;
      acc_r   <= '0;
      shift_r <= '0;
      flags_r <= '0;
      olen_r  <= '0;
      rem_r   <= '0;
      err_r   <= 1'b0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
      flags_r <= flags_nxt;
      olen_r  <= olen_nxt;
      rem_r   <= rem_nxt;
      err_r   <= err_nxt;
    end
  end

  // a latched error swallows everything
  assert property (@(posedge clk) disable iff (!rst_n) err_r |-> !push.v0)
    else $error("result produced while error latched");

  // a second result always closes the run
  assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> (push.v0 && push.r1.last && !push.r0.last))
    else $error("bad run marking on two-result transaction");

  // trailer counter stays within the digest length
  assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == bcd_pkg::PH_TRAILER) |-> (cnt_r <= bcd_pkg::CNT_W'(bcd_pkg::TRAILER_BYTES)))
    else $error("trailer counter out of range");

endmodule

// ----- rtl/bcd_outq.sv -----
module bcd_outq (
  input  logic             clk,
  input  logic             rst_n,
  input  bcd_pkg::push_t   push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_ready,
  output bcd_pkg::result_t head
);

  bcd_pkg::result_t          q_r [bcd_pkg::Q_DEPTH];
  logic [bcd_pkg::Q_AW-1:0]  wptr_r, wptr_nxt;
  logic [bcd_pkg::Q_AW-1:0]  rptr_r;
  logic [bcd_pkg::Q_AW:0]    cnt_r, cnt_nxt;
  logic [bcd_pkg::Q_AW-1:0]  wptr_p1;
  logic [1:0]                push_n;
  logic                      pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = (cnt_r != '0);
  assign head      = q_r[rptr_r];
  assign room      = (cnt_r <= (bcd_pkg::Q_AW+1)'(bcd_pkg::Q_DEPTH - 2));
  assign wptr_p1   = wptr_r + bcd_pkg::Q_AW'(1);
  assign push_n    = {1'b0, push.v0} + {1'b0, push.v1};
  assign wptr_nxt  = wptr_r + bcd_pkg::Q_AW'(push_n);
  assign cnt_nxt   = cnt_r + (bcd_pkg::Q_AW+1)'(push_n) - (bcd_pkg::Q_AW+1)'(pop);

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      cnt_r  <= cnt_nxt;
      if (pop) begin
        rptr_r <= rptr_r + bcd_pkg::Q_AW'(1);
      end
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push.v0) begin
      q_r[wptr_r] <= push.r0;
    end
    if (push.v1) begin
      q_r[wptr_p1] <= push.r1;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (bcd_pkg::Q_AW+1)'(bcd_pkg::Q_DEPTH))
    else $error("result queue overfilled");

  // a push needs two free entries
  assert property (@(posedge clk) disable iff (!rst_n)
    push.v0 |-> (cnt_r <= (bcd_pkg::Q_AW+1)'(bcd_pkg::Q_DEPTH - 2)))
    else $error("push without room");

  assert property (@(posedge clk) disable iff (!rst_n) push.v1 |-> push.v0)
    else $error("second result without first");

endmodule

// ----- rtl/block_container_deframer.sv -----
// channel | dir | tdata (low bit up)                                  | tuser | tlast
// in_     | in  | byte_in[7:0]                                        | -     | last_byte
// out_    | out | value, block_flags, original_length, payload_length, | kind  | last_of_run
//         |     | error_code, 5 zero bits                             |       |
// cfg_    | in  | cfg_wr_data = max_original_length, written on cfg_wr_en
//
// one byte per cycle sustained while the result queue has room
// an input register feeds the parser, whose results land in a four-entry result queue
// a byte causing two results writes both into the queue together; in_tready drops while a byte
// waits in the input register and the queue has fewer than two free entries
// reset is synchronous, active low, and clears all control state
module block_container_deframer (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // byte_in[7:0]
  input  logic                      in_tlast,
  input  logic                      cfg_wr_en,
  input  logic [bcd_pkg::LEN_W-1:0] cfg_wr_data,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // value[7:0], block_flags[15:8], original_length[79:16], payload_length[143:80],
  // error_code[146:144], zero fill[151:147]
  output logic [151:0]              out_tdata,
  output logic [2:0]                out_tuser,  // kind[2:0]
  output logic                      out_tlast
);

  bcd_pkg::push_t   push;
  bcd_pkg::result_t head;
  logic             room;

  bcd_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_byte     (in_tdata),
    .in_last     (in_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .room        (room),
    .push        (push)
  );

  bcd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .head      (head)
  );

  // pack head result onto the stream
  assign out_tdata = {5'b0, head.err, head.plen, head.olen, head.flags, head.value};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

// ----- verif/deframe_check.sv -----
module deframe_check (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  input  logic                      in_tready,
  input  logic [7:0]                in_tdata,   // byte_in[7:0]
  input  logic                      in_tlast,
  input  logic                      cfg_wr_en,
  input  logic [bcd_pkg::LEN_W-1:0] cfg_wr_data,
  input  logic                      out_tvalid,
  input  logic                      out_tready,
  // value[7:0], block_flags[15:8], original_length[79:16], payload_length[143:80],
  // error_code[146:144], zero fill[151:147]
  input  logic [151:0]              out_tdata,
  input  logic [2:0]                out_tuser,  // kind[2:0]
  input  logic                      out_tlast,
  output int unsigned               pending,
  output int unsigned               fail_count,
  output int unsigned               checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // container signature, first byte in the low bits
  localparam logic [31:0] SIGNATURE = 32'h3153_4150;

  typedef struct {
    bcd_pkg::kind_t            kind;
    logic [7:0]                value;
    logic [7:0]                flags;
    logic [bcd_pkg::LEN_W-1:0] olen;
    logic [bcd_pkg::LEN_W-1:0] plen;
    bcd_pkg::err_t             code;
    logic                      last;
  } frame_item_t;

  frame_item_t      due_q[$];

  // parser state and length cap
  bcd_pkg::phase_t  ph;
  logic [5:0]       cnt;
  logic [63:0]      acc;
  logic [6:0]       shift;
  logic [7:0]       hflags;
  logic [63:0]      holen;
  logic [63:0]      remaining;
  logic             latched;
  logic [63:0]      cap;
  int unsigned      made;

  function automatic void restart();
    ph        = bcd_pkg::PH_MAGIC;
    cnt       = '0;
    acc       = '0;
    shift     = '0;
    hflags    = '0;
    holen     = '0;
    remaining = '0;
    latched   = 1'b0;
  endfunction

  function automatic void emit(input bcd_pkg::kind_t k, input logic [7:0] v,
                               input logic [7:0] f, input logic [63:0] ol,
                               input logic [63:0] pl, input bcd_pkg::err_t c);
    frame_item_t r;
    r.kind  = k;
    r.value = v;
    r.flags = f;
    r.olen  = ol;
    r.plen  = pl;
    r.code  = c;
    r.last  = 1'b0;
    due_q.push_back(r);
    made++;
  endfunction

  // error result, then latch it or start over on the final byte
  function automatic void raise(input bcd_pkg::err_t c, input logic fin);
    emit(bcd_pkg::K_ERROR, 8'd0, 8'd0, '0, '0, c);
    if (fin) restart();
    else latched = 1'b1;
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic fin);
    logic [63:0] plen_v;
    frame_item_t r;
    made = 0;
    if (latched) begin
      if (fin) restart();
      return;
    end
    case (ph)
      bcd_pkg::PH_MAGIC: begin
        if (b != SIGNATURE[8*cnt[1:0] +: 8] || fin) begin
          raise(bcd_pkg::E_MAGIC, fin);
        end else begin
          cnt++;
          if (cnt >= 6'd4) begin
            cnt = '0;
            ph  = bcd_pkg::PH_TAG;
          end
        end
      end
      bcd_pkg::PH_TAG: begin
        if (b == bcd_pkg::TAG_END) begin
          if (fin) raise(bcd_pkg::E_TRAILER, 1'b1);
          else begin
            cnt = '0;
            ph  = bcd_pkg::PH_TRAILER;
          end
        end else if (b == bcd_pkg::TAG_BLOCK) begin
          if (fin) raise(bcd_pkg::E_TRUNC, 1'b1);
          else ph = bcd_pkg::PH_FLAGS;
        end else begin
          raise(bcd_pkg::E_TAG, fin);
        end
      end
      bcd_pkg::PH_FLAGS: begin
        if (fin) raise(bcd_pkg::E_TRUNC, 1'b1);
        else begin
          hflags = b;
          acc    = '0;
          shift  = '0;
          ph     = bcd_pkg::PH_ORIG;
        end
      end
      bcd_pkg::PH_ORIG, bcd_pkg::PH_COMP: begin
        // bits pushed past 63 fall off the top
        acc |= {57'd0, b[6:0]} << shift[5:0];
        if (b[7]) begin
          shift += 7'd7;
          if (shift >= 7'd64) raise(bcd_pkg::E_VARINT, fin);
          else if (fin) raise(bcd_pkg::E_TRUNC, 1'b1);
        end else if (ph == bcd_pkg::PH_ORIG) begin
          holen = acc;
          acc   = '0;
          shift = '0;
          if (fin) raise(bcd_pkg::E_TRUNC, 1'b1);
          else ph = bcd_pkg::PH_COMP;
        end else begin
          plen_v = acc;
          acc    = '0;
          shift  = '0;
          if (fin && plen_v != '0) begin
            raise(bcd_pkg::E_TRUNC, 1'b1);
          end else if (holen > cap) begin
            raise(bcd_pkg::E_CAP, fin);
          end else begin
            emit(bcd_pkg::K_HEADER, 8'd0, hflags, holen, plen_v, bcd_pkg::E_NONE);
            remaining = plen_v;
            ph        = (plen_v != '0) ? bcd_pkg::PH_PAYLOAD : bcd_pkg::PH_TAG;
            if (fin) raise(bcd_pkg::E_TRUNC, 1'b1);
          end
        end
      end
      bcd_pkg::PH_PAYLOAD: begin
        emit(bcd_pkg::K_DATA, b, 8'd0, '0, '0, bcd_pkg::E_NONE);
        if (remaining != '0) remaining--;
        if (remaining == '0) ph = bcd_pkg::PH_TAG;
        if (fin) raise(bcd_pkg::E_TRUNC, 1'b1);
      end
      default: begin
        // digest trailer
        if (cnt >= 6'(bcd_pkg::TRAILER_BYTES)) begin
          raise(bcd_pkg::E_TRAILER, fin);
        end else begin
          emit(bcd_pkg::K_DIGEST, b, 8'd0, '0, '0, bcd_pkg::E_NONE);
          cnt++;
          if (fin) begin
            if (cnt == 6'(bcd_pkg::TRAILER_BYTES)) begin
              emit(bcd_pkg::K_OK, 8'd0, 8'd0, '0, '0, bcd_pkg::E_NONE);
              restart();
            end else begin
              raise(bcd_pkg::E_TRAILER, 1'b1);
            end
          end
        end
      end
    endcase
    // tag the final result of this byte
    if (made > 0) begin
      r      = due_q.pop_back();
      r.last = 1'b1;
      due_q.push_back(r);
    end
  endfunction

  task automatic compare_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  // predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    frame_item_t w;
    if (!rst_n) begin
      restart();
      cap = bcd_pkg::MAX_OLEN_RST;
      due_q.delete();
      fail_count = 0;
      checked    = 0;
    end else begin
      if (cfg_wr_en) cap = cfg_wr_data;
      if (in_tvalid && in_tready) parse_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) begin
        if (due_q.size() == 0) begin
          $error("unexpected result: kind %0d, tdata %0h", out_tuser, out_tdata);
          fail_count++;
        end else begin
          w = due_q.pop_front();
          checked++;
          compare_field("kind", 64'(w.kind), 64'(out_tuser));
          compare_field("value", 64'(w.value), 64'(out_tdata[7:0]));
          compare_field("block_flags", 64'(w.flags), 64'(out_tdata[15:8]));
          compare_field("original_length", w.olen, out_tdata[79:16]);
          compare_field("payload_length", w.plen, out_tdata[143:80]);
          compare_field("error_code", 64'(w.code), 64'(out_tdata[146:144]));
          compare_field("last_of_run", 64'(w.last), 64'(out_tlast));
        end
      end
    end
    pending <= due_q.size();
  end

endmodule

// ----- verif/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ITEM_TARGET = 750;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned N_PHASES    = 6;

  typedef enum int {
    SHAPE_GOOD,
    SHAPE_TRUNC,
    SHAPE_CAP,
    SHAPE_OVERFLOW,
    SHAPE_BADTAG,
    SHAPE_BADMAGIC,
    SHAPE_LONGTRAIL,
    SHAPE_SHORTTRAIL
  } shape_t;

  logic                      clk         = 1'b0;
  logic                      rst_n       = 1'b0;
  logic                      in_tvalid   = 1'b0;
  logic                      in_tready;
  logic [7:0]                in_tdata    = '0;
  logic                      in_tlast    = 1'b0;
  logic                      cfg_wr_en   = 1'b0;
  logic [bcd_pkg::LEN_W-1:0] cfg_wr_data = '0;
  logic                      out_tvalid;
  logic                      out_tready  = 1'b0;
  logic [151:0]              out_tdata;
  logic [2:0]                out_tuser;
  logic                      out_tlast;

  int unsigned        pending;
  int unsigned        fail_count;
  int unsigned        checked;

  // stimulus bookkeeping
  logic [8:0]         cont_q[$];   // {last, byte}
  logic [63:0]        cur_cap = bcd_pkg::MAX_OLEN_RST;
  int unsigned        send_idle;
  int unsigned        recv_idle;
  int unsigned        bytes_sent;
  int unsigned        containers;
  int unsigned        quiet;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  block_container_deframer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  deframe_check u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .pending     (pending),
    .fail_count  (fail_count),
    .checked     (checked)
  );

  // random backpressure on the result side
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet == STALL_LIMIT) begin
      $display("FAIL block_container_deframer");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_byte(input logic [8:0] e);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= e[7:0];
    in_tlast  <= e[8];
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_container();
    while (cont_q.size() != 0) send_byte(cont_q.pop_front());
    containers++;
  endtask

  // byte count for a length: usually minimal, sometimes padded up to ten
  function automatic int unsigned varint_len(input logic [63:0] v);
    int unsigned n;
    n = 1;
    while (n < 10 && (v >> (7 * n)) != '0) n++;
    if ($urandom_range(0, 3) == 0) n = $urandom_range(n, 10);
    return n;
  endfunction

  task automatic push_varint(input logic [63:0] v, input int unsigned n);
    logic [69:0] wide;
    logic [7:0]  b;
    int unsigned i;
    wide = {6'd0, v};
    for (i = 0; i < n; i++) begin
      b = {1'b0, wide[7*i +: 7]};
      // tenth byte: bits above 63 are junk that must be dropped
      if (i == 9) b[6:1] = 6'($urandom_range(0, 63));
      if (i + 1 < n) b[7] = 1'b1;
      cont_q.push_back({1'b0, b});
    end
  endtask

  task automatic push_random(input int unsigned n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom_range(0, 255));
      cont_q.push_back({1'b0, b});
    end
  endtask

  function automatic logic [63:0] pick_olen();
    logic [63:0] v;
    case ($urandom_range(0, 5))
      0:       v = 64'($urandom_range(0, 127));
      1:       v = '1;
      2:       v = bcd_pkg::MAX_OLEN_RST;
      3:       v = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: v = 64'($urandom_range(0, 100000));
    endcase
    return v;
  endfunction

  function automatic shape_t pick_shape();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return SHAPE_GOOD;
    if (r < 65) return SHAPE_TRUNC;
    if (r < 73) return SHAPE_CAP;
    if (r < 80) return SHAPE_OVERFLOW;
    if (r < 86) return SHAPE_BADTAG;
    if (r < 91) return SHAPE_BADMAGIC;
    if (r < 96) return SHAPE_LONGTRAIL;
    return SHAPE_SHORTTRAIL;
  endfunction

  task automatic push_signature();
    int unsigned i;
    for (i = 0; i < 4; i++) cont_q.push_back({1'b0, bcd_pkg::magic_byte(i[1:0])});
  endtask

  // well-formed container with random content, then broken where the shape says
  task automatic build_container(input shape_t shape);
    int unsigned nblk, pick, i, n, cut, err_at, digest_n;
    bit          has_err;
    logic [63:0] olen, plen;
    logic [7:0]  b;
    logic [8:0]  e;
    cont_q.delete();
    has_err = 0;
    err_at  = 0;
    push_signature();
    if (shape == SHAPE_BADMAGIC) begin
      i         = $urandom_range(0, 3);
      b         = 8'($urandom_range(1, 255));
      cont_q[i] = {1'b0, cont_q[i][7:0] ^ b};
      err_at    = i;
      has_err   = 1;
    end
    nblk = $urandom_range(0, 3);
    if ((shape == SHAPE_CAP || shape == SHAPE_OVERFLOW) && nblk == 0) nblk = 1;
    pick = (nblk > 0) ? $urandom_range(0, nblk - 1) : 0;
    for (i = 0; i < nblk; i++) begin
      cont_q.push_back({1'b0, bcd_pkg::TAG_BLOCK});
      push_random(1);
      olen = pick_olen();
      if (shape == SHAPE_CAP && i == pick && cur_cap != '1) begin
        olen = $urandom_range(0, 1) ? cur_cap + 64'd1 : '1;
      end else if (olen > cur_cap && cur_cap != '1) begin
        olen = olen % (cur_cap + 64'd1);
      end
      if (shape == SHAPE_OVERFLOW && i == pick) begin
        // ten continuation bytes in one of the two lengths
        if ($urandom_range(0, 1) == 1) push_varint(olen, varint_len(olen));
        repeat (10) begin
          b = 8'($urandom_range(0, 127)) | 8'h80;
          cont_q.push_back({1'b0, b});
        end
        err_at  = cont_q.size() - 1;
        has_err = 1;
        break;
      end
      push_varint(olen, varint_len(olen));
      if (shape == SHAPE_TRUNC && i == pick && $urandom_range(0, 1) == 1) begin
        // huge declared payload, stream stops partway through it
        plen = {$urandom, $urandom} | 64'h40;
        push_varint(plen, varint_len(plen));
        push_random($urandom_range(1, 5));
        err_at  = cont_q.size() - 1;
        has_err = 1;
        break;
      end
      plen = 64'($urandom_range(0, 6));
      push_varint(plen, varint_len(plen));
      if (shape == SHAPE_CAP && i == pick && cur_cap != '1) begin
        err_at  = cont_q.size() - 1;
        has_err = 1;
      end
      push_random(32'(plen));
    end
    if (shape == SHAPE_BADTAG) begin
      b = 8'($urandom_range(2, 255));
      cont_q.push_back({1'b0, b});
      err_at  = cont_q.size() - 1;
      has_err = 1;
    end
    cont_q.push_back({1'b0, bcd_pkg::TAG_END});
    digest_n = bcd_pkg::TRAILER_BYTES;
    if (shape == SHAPE_LONGTRAIL) digest_n += $urandom_range(1, 3);
    if (shape == SHAPE_SHORTTRAIL) digest_n = $urandom_range(0, bcd_pkg::TRAILER_BYTES - 1);
    push_random(digest_n);
    // where the final byte falls
    if (has_err) begin
      n   = err_at + $urandom_range(0, 3);
      cut = (n < cont_q.size()) ? n : cont_q.size() - 1;
    end else if (shape == SHAPE_TRUNC) begin
      cut = $urandom_range(0, cont_q.size() - 2);
    end else begin
      cut = cont_q.size() - 1;
    end
    while (cont_q.size() > cut + 1) void'(cont_q.pop_back());
    e           = cont_q[cut];
    e[8]        = 1'b1;
    cont_q[cut] = e;
  endtask

  // let every expected result out and the pipeline empty
  task automatic settle();
    in_tvalid <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cap(input logic [63:0] v);
    cfg_wr_data <= v;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_cap      = v;
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0:       begin send_idle = 16; recv_idle = 77; end
      1:       begin send_idle = 77; recv_idle = 16; end
      default: begin send_idle = 0;  recv_idle = 0;  end
    endcase
  endtask

  initial begin
    logic [7:0]  lone_tags [3];
    logic [63:0] cap_v;
    int unsigned ph_i, t;

    set_idling(0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: signature errors, lone tags on the final byte
    cont_q = '{9'h000, 9'h1ff};
    send_container();
    cont_q = '{{1'b0, bcd_pkg::magic_byte(2'd0)}, {1'b1, bcd_pkg::magic_byte(2'd1)}};
    send_container();
    lone_tags = '{8'hff, bcd_pkg::TAG_END, bcd_pkg::TAG_BLOCK};
    for (t = 0; t < 3; t++) begin
      cont_q.delete();
      push_signature();
      cont_q.push_back({1'b1, lone_tags[t]});
      send_container();
    end

    // random containers under a range of length caps
    for (ph_i = 0; ph_i < N_PHASES; ph_i++) begin
      settle();
      case (ph_i)
        0:       cap_v = '1;
        1:       cap_v = '0;
        2:       cap_v = {$urandom, $urandom} >> $urandom_range(0, 40);
        3:       cap_v = bcd_pkg::MAX_OLEN_RST;
        4:       cap_v = 64'd1;
        default: cap_v = 64'($urandom_range(0, 1000));
      endcase
      write_cap(cap_v);
      set_idling(ph_i / 2);
      while (bytes_sent < ITEM_TARGET * (ph_i + 1) / N_PHASES) begin
        build_container(pick_shape());
        send_container();
      end
    end
    settle();

    $display("streamed %0d bytes in %0d containers over %0d length-cap settings",
             bytes_sent, containers, N_PHASES + 1);
    $display("compared %0d results, %0d mismatches", checked, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS block_container_deframer");
    end else begin
      $display("FAIL block_container_deframer");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bcd_pkg.sv
rtl/bcd_parse.sv
rtl/bcd_outq.sv
rtl/block_container_deframer.sv
verif/deframe_check.sv
verif/tb.sv
